[src/sem_pkg.sv]
`timescale 1ns / 1ps
package sem_pkg;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int CNT_W       = 12;
    localparam int COL_AW      = $clog2(MAX_WIDTH);
    localparam int COORD_W     = 11;
    localparam int MAG_W       = 11;
    localparam int SQ_W        = 22;
    localparam int SQRT_STEPS  = SQ_W / 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
    localparam logic [CNT_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CNT_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_SQUARE,
        ST_ROOT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic shift;
        logic square;
        logic root_start;
        logic root_step;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic root_done;
    } status_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [MAG_W-1:0]   magnitude;
        logic               frame_last;
    } result_t;
endpackage

[src/sem_stream_if.sv]
`timescale 1ns / 1ps
interface sem_pixel_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_color;
    modport source (output valid, output pixel_color, input ready);
    modport sink (input valid, input pixel_color, output ready);
endinterface

interface sem_result_if;
    logic                         valid;
    logic                         ready;
    logic [sem_pkg::COORD_W-1:0] center_x;
    logic [sem_pkg::COORD_W-1:0] center_y;
    logic [sem_pkg::MAG_W-1:0]   magnitude;
    logic                         frame_last;
    modport source (output valid, output center_x, output center_y, output magnitude,
                    output frame_last, input ready);
    modport sink (input valid, input center_x, input center_y, input magnitude,
                  input frame_last, output ready);
endinterface

[src/sobel_edge_magnitude_top.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload
// pix_in    in   pixel_color[23:0]
// res_out   out  center_x, center_y, magnitude, frame_last
// cfg       in   cfg_write, cfg_index, cfg_data (width, height)
// One item at a time: an item without a result runs load, read and shift; one
// with a result adds square, root (11 steps, one result bit per cycle) and out;
// the result is valid from the next cycle in the output register. Reset clears
// counters, window, state and flags; line stores and data registers hold no
// reset value. A stalled result holds the block only if a second one is ready.
module sobel_edge_magnitude_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    sem_pixel_if.sink                       pix_in,
    sem_result_if.source                    res_out
);
    sem_pkg::cmd_t    cmd;
    sem_pkg::status_t status;
    sem_pkg::result_t result;

    // sequence each item through read and window shift, a result through root
    sem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // line stores, window, kernels and root
    sem_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_color (pix_in.pixel_color),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

    assign res_out.center_x   = result.center_x;
    assign res_out.center_y   = result.center_y;
    assign res_out.magnitude  = result.magnitude;
    assign res_out.frame_last = result.frame_last;
endmodule

[src/sem_ctrl.sv]
`timescale 1ns / 1ps
module sem_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sem_pkg::status_t  status,
    output sem_pkg::cmd_t     cmd
);
    sem_pkg::state_t state_reg, state_next;
    logic full_reg, full_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sem_pkg::ST_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = full_reg;
        // drop the held result once it is taken
        full_next  = full_reg && !out_ready;
        unique case (state_reg)
            sem_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sem_pkg::ST_READ;
                end
            end
            sem_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = sem_pkg::ST_SHIFT;
            end
            sem_pkg::ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = status.emit ? sem_pkg::ST_SQUARE : sem_pkg::ST_IDLE;
            end
            sem_pkg::ST_SQUARE:
            begin
                cmd.square     = 1'b1;
                cmd.root_start = 1'b1;
                state_next     = sem_pkg::ST_ROOT;
            end
            sem_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                begin
                    state_next = sem_pkg::ST_OUT;
                end
            end
            sem_pkg::ST_OUT:
            begin
                // hold until the output register is free
                if (!full_reg || out_ready)
                begin
                    cmd.capture = 1'b1;
                    full_next   = 1'b1;
                    state_next  = sem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && !out_ready) |=> full_reg)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sem_pkg::ST_OUT && full_reg && !out_ready)
        |=> state_reg == sem_pkg::ST_OUT)
        else $error("held result overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sem_pkg::ST_SHIFT && !status.emit) |=> state_reg == sem_pkg::ST_IDLE)
        else $error("no-result item did not retire");
endmodule

[src/sem_datapath.sv]
`timescale 1ns / 1ps
module sem_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [23:0]                        pixel_color,
    input  sem_pkg::cmd_t                      cmd,
    output sem_pkg::status_t                   status,
    output sem_pkg::result_t                   result
);
    localparam int CW = sem_pkg::CNT_W;

    logic [CW-1:0] width_cfg_reg, height_cfg_reg;
    logic [CW-1:0] col_reg, col_next, row_reg, row_next;
    logic [CW-1:0] w_eff, h_eff;
    logic [7:0] upper_mem [sem_pkg::MAX_WIDTH];
    logic [7:0] middle_mem [sem_pkg::MAX_WIDTH];
    logic [7:0] top_rd_reg, mid_rd_reg;
    logic [7:0] gray_reg;
    logic [9:0] sum3;
    logic [7:0] gray_q;
    logic       in_col_reg;
    logic [7:0] win_reg [9];
    logic       emit_reg;
    logic       last_reg;
    logic [CW-1:0] cx_reg, cy_reg;
    logic signed [11:0] gx, gy;
    logic signed [sem_pkg::SQ_W-1:0] gx_wide, gy_wide;
    logic [sem_pkg::SQ_W-1:0] sq_reg;
    logic [sem_pkg::SQ_W-1:0] rem_reg;
    logic [sem_pkg::MAG_W-1:0] root_reg;
    logic [$clog2(sem_pkg::SQRT_STEPS+1)-1:0] step_reg;
    logic [sem_pkg::SQ_W-1:0] trial;
    logic [sem_pkg::SQ_W-1:0] rem_sh;
    sem_pkg::result_t result_reg;

    always_comb
    begin
        if (width_cfg_reg < CW'(2))
            w_eff = CW'(2);
        else if (width_cfg_reg > CW'(sem_pkg::MAX_WIDTH))
            w_eff = CW'(sem_pkg::MAX_WIDTH);
        else
            w_eff = width_cfg_reg;
        if (height_cfg_reg < CW'(2))
            h_eff = CW'(2);
        else if (height_cfg_reg > CW'(sem_pkg::MAX_HEIGHT))
            h_eff = CW'(sem_pkg::MAX_HEIGHT);
        else
            h_eff = height_cfg_reg;
    end

    // divide by three via small reciprocal: (s*683)>>11 is exact for s<=765
    assign sum3   = 10'(pixel_color[7:0]) + 10'(pixel_color[15:8]) + 10'(pixel_color[23:16]);
    assign gray_q = 8'((21'(sum3) * 21'd683) >> 11);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_reg >= w_eff)
        begin
            col_next = '0;
            row_next = (row_reg >= h_eff) ? '0 : row_reg + CW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
            if (row_reg > h_eff)
                row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= sem_pkg::WIDTH_RESET;
            height_cfg_reg <= sem_pkg::HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            emit_reg       <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == sem_pkg::REG_WIDTH)
                    width_cfg_reg <= cfg_data;
                else
                    height_cfg_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                emit_reg <= col_reg >= CW'(2) && row_reg >= CW'(2)
                            && col_reg <= w_eff && row_reg <= h_eff;
                col_reg  <= col_next;
                row_reg  <= row_next;
            end
            if (cmd.shift)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i*3]   <= win_reg[i*3+1];
                    win_reg[i*3+1] <= win_reg[i*3+2];
                end
                win_reg[2] <= in_col_reg ? top_rd_reg : 8'd0;
                win_reg[5] <= in_col_reg ? mid_rd_reg : 8'd0;
                win_reg[8] <= gray_reg;
            end
        end
    end

    // load: register gray and position; read: memory access
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            gray_reg   <= (col_reg >= w_eff || row_reg >= h_eff) ? 8'd0 : gray_q;
            in_col_reg <= col_reg < w_eff;
            cx_reg     <= col_reg - CW'(1);
            cy_reg     <= row_reg - CW'(1);
            last_reg   <= col_reg == w_eff && row_reg == h_eff;
        end
        if (cmd.read)
        begin
            top_rd_reg <= upper_mem[cx_reg[sem_pkg::COL_AW-1:0] + sem_pkg::COL_AW'(1)];
            mid_rd_reg <= middle_mem[cx_reg[sem_pkg::COL_AW-1:0] + sem_pkg::COL_AW'(1)];
        end
        if (cmd.shift && in_col_reg)
        begin
            upper_mem[cx_reg[sem_pkg::COL_AW-1:0] + sem_pkg::COL_AW'(1)]  <= mid_rd_reg;
            middle_mem[cx_reg[sem_pkg::COL_AW-1:0] + sem_pkg::COL_AW'(1)] <= gray_reg;
        end
    end

    assign gx = (12'(win_reg[2]) + (12'(win_reg[5]) << 1) + 12'(win_reg[8]))
              - (12'(win_reg[0]) + (12'(win_reg[3]) << 1) + 12'(win_reg[6]));
    assign gy = (12'(win_reg[6]) + (12'(win_reg[7]) << 1) + 12'(win_reg[8]))
              - (12'(win_reg[0]) + (12'(win_reg[1]) << 1) + 12'(win_reg[2]));
    assign gx_wide = sem_pkg::SQ_W'(gx);
    assign gy_wide = sem_pkg::SQ_W'(gy);

    // bit-pair restoring square root, one result bit per step
    assign rem_sh = {rem_reg[sem_pkg::SQ_W-3:0], sq_reg[sem_pkg::SQ_W-1 -: 2]};
    assign trial  = sem_pkg::SQ_W'({root_reg, 2'b01});

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            sq_reg   <= sem_pkg::SQ_W'(gx_wide * gx_wide) + sem_pkg::SQ_W'(gy_wide * gy_wide);
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            sq_reg   <= sq_reg << 2;
            step_reg <= step_reg + 1'b1;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[sem_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[sem_pkg::MAG_W-2:0], 1'b0};
            end
        end
    end

    // output register: hold the finished result while the next item runs
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            result_reg.center_x   <= cx_reg[sem_pkg::COORD_W-1:0];
            result_reg.center_y   <= cy_reg[sem_pkg::COORD_W-1:0];
            result_reg.magnitude  <= root_reg;
            result_reg.frame_last <= last_reg;
        end
    end

    assign status.emit      = emit_reg;
    assign status.root_done = step_reg == ($bits(step_reg))'(sem_pkg::SQRT_STEPS - 1)
                              && cmd.root_step;
    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (col_reg == '0) || (col_reg == $past(col_reg) + CW'(1)))
        else $error("column counter skipped");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.square |-> emit_reg)
        else $error("magnitude started without a window");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.square && cmd.root_step))
        else $error("square and root overlap");
endmodule
